### hdl/pae_pkg.sv
package pae_pkg;

    // Default alignment position width.
    localparam int POSITION_WIDTH_DEF = 40;

    // Fixed field widths.
    localparam int CFG_W      = 40;   // widest configuration register
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 6;    // offset_bit_count, insert_bit_count, distance_bits
    localparam int MISMATCH_W = 32;
    localparam int INDEX_W    = 33;
    localparam int OFFSET_W   = 40;
    localparam int DIST_W     = 40;
    localparam int REL_W      = 2;

    localparam logic [MISMATCH_W-1:0] UNMAPPED = {MISMATCH_W{1'b1}};

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [REL_W-1:0]     rel_code_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_OFFSET_BIT_COUNT = 3'd0;
    localparam cfg_idx_t CFG_OFFSET_MASK      = 3'd1;
    localparam cfg_idx_t CFG_INSERT_LIMIT     = 3'd2;
    localparam cfg_idx_t CFG_INSERT_BIT_COUNT = 3'd3;
    localparam cfg_idx_t CFG_REFERENCE_LENGTH = 3'd4;

    // Pair relation codes.
    localparam rel_code_t REL_NEAR_BEFORE = 2'd0;
    localparam rel_code_t REL_NEAR_AFTER  = 2'd1;
    localparam rel_code_t REL_FAR_BEFORE  = 2'd2;
    localparam rel_code_t REL_FAR_AFTER   = 2'd3;

    // Register reset values.
    localparam logic [COUNT_W-1:0] OFFSET_BIT_COUNT_RST = 6'd24;
    localparam logic [CFG_W-1:0]   OFFSET_MASK_RST      = 40'hff_ffff;
    localparam logic [CFG_W-1:0]   INSERT_LIMIT_RST     = 40'd512;
    localparam logic [COUNT_W-1:0] INSERT_BIT_COUNT_RST = 6'd9;
    localparam logic [CFG_W-1:0]   REFERENCE_LENGTH_RST = 40'd0;

endpackage

### hdl/pae_pair_if.sv
interface pae_pair_if #(
    parameter int POSITION_WIDTH = pae_pkg::POSITION_WIDTH_DEF
);
    import pae_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POSITION_WIDTH-1:0] position_first;
    logic [POSITION_WIDTH-1:0] position_second;
    logic [MISMATCH_W-1:0]     mismatches_first;
    logic [MISMATCH_W-1:0]     mismatches_second;

    modport source (
        output valid, position_first, position_second, mismatches_first, mismatches_second,
        input  ready
    );

    modport sink (
        input  valid, position_first, position_second, mismatches_first, mismatches_second,
        output ready
    );

endinterface

### hdl/pae_result_if.sv
interface pae_result_if;
    import pae_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  block_index_first;
    logic [INDEX_W-1:0]  block_index_second;
    logic                offset_valid;
    logic [OFFSET_W-1:0] block_offset;
    logic                relation_valid;
    logic [REL_W-1:0]    pair_relation;
    logic [DIST_W-1:0]   distance_value;
    logic [COUNT_W-1:0]  distance_bits;

    modport source (
        output valid, block_index_first, block_index_second, offset_valid, block_offset,
               relation_valid, pair_relation, distance_value, distance_bits,
        input  ready
    );

    modport sink (
        input  valid, block_index_first, block_index_second, offset_valid, block_offset,
               relation_valid, pair_relation, distance_value, distance_bits,
        output ready
    );

endinterface

### hdl/paired_alignment_position_encoder.sv
// An accepted pair item passes the input register, then the result register, to the result channel.
// Throughput: 1 pair item per cycle while the result channel is ready; one input register feeds
// a single pass of compare, subtract and bit-length logic into one result register.
// Reset (rst_n, async, active low): pipeline emptied, configuration registers to their
// defaults (offset bits 24, mask 0xffffff, insert limit 512, insert bits 9, ref length 0).
module paired_alignment_position_encoder #(
    parameter int POSITION_WIDTH = pae_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pae_pair_if.sink                  pair,
    pae_result_if.source              result,
    input  logic                      cfg_we,
    input  pae_pkg::cfg_idx_t         cfg_index,
    input  logic [pae_pkg::CFG_W-1:0] cfg_data
);
    import pae_pkg::*;

    // Working width: wide enough for positions and for the 40-bit registers.
    localparam int CW = (POSITION_WIDTH > CFG_W) ? POSITION_WIDTH : CFG_W;
    localparam int LEN_W = $clog2(CW + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] offset_bit_count_reg;
    logic [CFG_W-1:0]   offset_mask_reg;
    logic [CFG_W-1:0]   insert_limit_reg;
    logic [COUNT_W-1:0] insert_bit_count_reg;
    logic [CFG_W-1:0]   reference_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bit_count_reg <= OFFSET_BIT_COUNT_RST;
            offset_mask_reg      <= OFFSET_MASK_RST;
            insert_limit_reg     <= INSERT_LIMIT_RST;
            insert_bit_count_reg <= INSERT_BIT_COUNT_RST;
            reference_length_reg <= REFERENCE_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_BIT_COUNT: offset_bit_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_OFFSET_MASK:      offset_mask_reg      <= cfg_data;
                CFG_INSERT_LIMIT:     insert_limit_reg     <= cfg_data;
                CFG_INSERT_BIT_COUNT: insert_bit_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_REFERENCE_LENGTH: reference_length_reg <= cfg_data;
                default:              ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input stage and result stage, each drains as soon as the
    // one after it has room, so one item moves per cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s2_ready;
    logic s1_ready;
    logic pair_take;

    assign s2_ready  = !out_valid_reg || result.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pair_take = pair.valid && s1_ready;
    assign pair.ready = s1_ready;

    assign s1_valid_next  = s1_ready ? pair.valid : s1_valid_reg;
    assign out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register (payload, no reset).
    logic [POSITION_WIDTH-1:0] pos_first_reg;
    logic [POSITION_WIDTH-1:0] pos_second_reg;
    logic                      mapped_first_reg;
    logic                      mapped_second_reg;

    always_ff @(posedge clk)
    begin
        if (pair_take)
        begin
            pos_first_reg     <= pair.position_first;
            pos_second_reg    <= pair.position_second;
            mapped_first_reg  <= (pair.mismatches_first != UNMAPPED);
            mapped_second_reg <= (pair.mismatches_second != UNMAPPED);
        end
    end

    // ------------------------------------------------------------------
    // Encode logic
    // ------------------------------------------------------------------
    function automatic logic [LEN_W-1:0] bit_len(input logic [CW-1:0] x);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (x[i])
                n = LEN_W'(i + 1);
        end
        return n;
    endfunction

    logic [CW-1:0]       p0;
    logic [CW-1:0]       p1;
    logic [CW-1:0]       sel_pos;        // position of the first mapped mate
    logic [CW-1:0]       shifted;
    logic [INDEX_W-1:0]  index_sel;
    logic [CW-1:0]       offset_low;
    logic [CW-1:0]       diff;
    logic                after;
    logic                near;
    logic [CW-1:0]       room;
    logic [CW-1:0]       dval_raw;
    logic [LEN_W-1:0]    dbits_raw;      // can reach CW before truncation to 6 bits
    logic [CW-1:0]       dval_masked;
    logic [LEN_W-1:0]    len_p0;
    logic [LEN_W-1:0]    len_room;
    rel_code_t           rel;
    logic                both;
    logic                any;

    logic [INDEX_W-1:0]  index_first_next;
    logic [INDEX_W-1:0]  index_second_next;
    logic [OFFSET_W-1:0] offset_next;
    logic                rel_valid_next;
    rel_code_t           rel_next;
    logic [DIST_W-1:0]   dval_next;
    logic [COUNT_W-1:0]  dbits_next;

    always_comb
    begin
        p0   = CW'(pos_first_reg);
        p1   = CW'(pos_second_reg);
        both = mapped_first_reg && mapped_second_reg;
        any  = mapped_first_reg || mapped_second_reg;

        sel_pos   = mapped_first_reg ? p0 : p1;
        shifted   = sel_pos >> offset_bit_count_reg;
        index_sel = {1'b0, shifted[31:0]} + INDEX_W'(1);

        // Offset: mask register, then keep offset_bit_count low bits.
        offset_low = sel_pos & CW'(offset_mask_reg) & ~({CW{1'b1}} << offset_bit_count_reg);

        after = p1 > p0;
        diff  = after ? (p1 - p0) : (p0 - p1);
        near  = diff < CW'(insert_limit_reg);
        room  = (CW'(reference_length_reg) > p0) ? (CW'(reference_length_reg) - p0) : '0;

        len_p0   = bit_len(p0);
        len_room = bit_len(room);

        if (near)
        begin
            rel       = after ? REL_NEAR_AFTER : REL_NEAR_BEFORE;
            dval_raw  = diff;
            dbits_raw = LEN_W'(insert_bit_count_reg);
        end
        else if (!after)
        begin
            rel       = REL_FAR_BEFORE;
            dval_raw  = p1;
            dbits_raw = len_p0;
        end
        else
        begin
            rel       = REL_FAR_AFTER;
            dval_raw  = diff;
            dbits_raw = len_room;
        end
        dval_masked = dval_raw & ~({CW{1'b1}} << dbits_raw);

        index_first_next  = mapped_first_reg ? index_sel : '0;
        index_second_next = mapped_second_reg ? index_sel : '0;
        offset_next       = any ? OFFSET_W'(offset_low) : '0;
        rel_valid_next    = both;
        rel_next          = both ? rel : REL_NEAR_BEFORE;
        dval_next         = both ? DIST_W'(dval_masked) : '0;
        dbits_next        = both ? dbits_raw[COUNT_W-1:0] : '0;
    end

    // Result register (payload, no reset).
    logic [INDEX_W-1:0]  index_first_reg;
    logic [INDEX_W-1:0]  index_second_reg;
    logic                offset_valid_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                rel_valid_reg;
    rel_code_t           rel_reg;
    logic [DIST_W-1:0]   dval_reg;
    logic [COUNT_W-1:0]  dbits_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            index_first_reg  <= index_first_next;
            index_second_reg <= index_second_next;
            offset_valid_reg <= any;
            offset_reg       <= offset_next;
            rel_valid_reg    <= rel_valid_next;
            rel_reg          <= rel_next;
            dval_reg         <= dval_next;
            dbits_reg        <= dbits_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.block_index_first  = index_first_reg;
    assign result.block_index_second = index_second_reg;
    assign result.offset_valid       = offset_valid_reg;
    assign result.block_offset       = offset_reg;
    assign result.relation_valid     = rel_valid_reg;
    assign result.pair_relation      = rel_reg;
    assign result.distance_value     = dval_reg;
    assign result.distance_bits      = dbits_reg;

`ifndef SYNTHESIS
    // Both mates mapped: offset present and both indexes carry the first mate's block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.relation_valid) |->
            (result.offset_valid && result.block_index_first == result.block_index_second
             && result.block_index_first != '0))
        else $error("paired result without matching block indexes");

    // No relation: relation fields all zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.relation_valid) |->
            (result.pair_relation == REL_NEAR_BEFORE && result.distance_value == '0
             && result.distance_bits == '0))
        else $error("relation fields set without a relation");

    // Offset flag agrees with the block indexes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.offset_valid == (result.block_index_first != '0
                                     || result.block_index_second != '0)))
        else $error("offset flag disagrees with block indexes");

    // An item held in the input stage is not dropped while the result stage stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("input stage item lost under stall");

    // An empty result stage never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pair.ready)
        else $error("input stalled with empty result stage");
`endif

endmodule

### tb/paired_alignment_position_encoder_tb.sv
`timescale 1ns / 1ps

module paired_alignment_position_encoder_tb;
    import pae_pkg::*;

    localparam int POS_W = POSITION_WIDTH_DEF;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Indexes past the end of the register map; writes there must be dropped.
    localparam cfg_idx_t CFG_SPARE_FIRST = 3'd5;
    localparam cfg_idx_t CFG_SPARE_LAST  = 3'd7;

    // Watchdog: cycles without any handshake before we give up.  The long
    // receiver hold-off below is set by HOLD_CYCLES, well under this limit.
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 8;    // pipeline is 2 deep
    localparam int unsigned BATCH_ITEMS = 142;

    // One read pair as presented on the pair channel.
    typedef struct packed {
        logic [POS_W-1:0]      position_first;
        logic [POS_W-1:0]      position_second;
        logic [MISMATCH_W-1:0] mismatches_first;
        logic [MISMATCH_W-1:0] mismatches_second;
    } pair_item_t;

    // The encoded result for one pair.
    typedef struct packed {
        logic [INDEX_W-1:0]  index_first;
        logic [INDEX_W-1:0]  index_second;
        logic                offset_valid;
        logic [OFFSET_W-1:0] block_offset;
        logic                relation_valid;
        rel_code_t           relation;
        logic [DIST_W-1:0]   distance_value;
        logic [COUNT_W-1:0]  distance_bits;
    } encoding_t;

    // Testbench copy of the register file.
    typedef struct packed {
        logic [COUNT_W-1:0] offset_bits;
        logic [CFG_W-1:0]   offset_mask;
        logic [CFG_W-1:0]   insert_limit;
        logic [COUNT_W-1:0] insert_bits;
        logic [CFG_W-1:0]   reference_length;
    } encoder_cfg_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    cfg_idx_t          cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    pae_pair_if #(.POSITION_WIDTH(POS_W)) pair_ch ();
    pae_result_if                         result_ch ();

    paired_alignment_position_encoder #(
        .POSITION_WIDTH(POS_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pairs waiting for the driver, and encodings waiting for the block.
    pair_item_t   pairs_to_send[$];
    encoding_t    predicted_codes[$];
    encoder_cfg_t cfg_now;

    int unsigned  error_count = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    logic         recv_hold = 1'b0;
    event         recv_hold_req;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] ones_below(input int unsigned n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Number of significant bits; zero has none.
    function automatic int unsigned bit_span(input logic [63:0] x);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                n = i + 1;
        return n;
    endfunction

    // Block index plus one, index kept to 32 bits.
    function automatic logic [INDEX_W-1:0] block_number(input logic [POS_W-1:0] pos,
                                                        input logic [COUNT_W-1:0] shift);
        logic [63:0] shifted;
        shifted = {{(64-POS_W){1'b0}}, pos} >> shift;
        return {1'b0, shifted[31:0]} + 33'd1;
    endfunction

    function automatic logic [OFFSET_W-1:0] in_block_offset(input logic [POS_W-1:0] pos,
                                                            input encoder_cfg_t c);
        logic [63:0] masked;
        masked = {{(64-POS_W){1'b0}}, pos} & {24'd0, c.offset_mask}
                 & ones_below(32'(c.offset_bits)) & ones_below(OFFSET_W);
        return masked[OFFSET_W-1:0];
    endfunction

    function automatic encoding_t encode_pair(input pair_item_t p, input encoder_cfg_t c);
        encoding_t   e;
        logic        mapped_a;
        logic        mapped_b;
        logic        after;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] diff;
        logic [63:0] room;
        logic [63:0] dval;
        int unsigned dbits;
        e = '0;
        pa = {{(64-POS_W){1'b0}}, p.position_first};
        pb = {{(64-POS_W){1'b0}}, p.position_second};
        mapped_a = p.mismatches_first != UNMAPPED;
        mapped_b = p.mismatches_second != UNMAPPED;
        if (mapped_a && mapped_b)
        begin
            diff = (pa >= pb) ? pa - pb : pb - pa;
            after = pb > pa;
            e.index_first = block_number(p.position_first, c.offset_bits);
            e.index_second = e.index_first;
            e.offset_valid = 1'b1;
            e.block_offset = in_block_offset(p.position_first, c);
            e.relation_valid = 1'b1;
            if (diff < {24'd0, c.insert_limit})
            begin
                e.relation = after ? REL_NEAR_AFTER : REL_NEAR_BEFORE;
                dval = diff;
                dbits = 32'(c.insert_bits);
            end
            else if (!after)
            begin
                // far, second at or before first: code the second position itself
                e.relation = REL_FAR_BEFORE;
                dval = pb;
                dbits = bit_span(pa);
            end
            else
            begin
                // far, second after first: width from room left to reference end
                room = ({24'd0, c.reference_length} > pa) ? {24'd0, c.reference_length} - pa
                                                          : 64'd0;
                e.relation = REL_FAR_AFTER;
                dval = diff;
                dbits = bit_span(room);
            end
            dval = dval & ones_below(dbits);
            e.distance_value = dval[DIST_W-1:0];
            e.distance_bits = dbits[COUNT_W-1:0];
        end
        else if (mapped_a)
        begin
            e.index_first = block_number(p.position_first, c.offset_bits);
            e.offset_valid = 1'b1;
            e.block_offset = in_block_offset(p.position_first, c);
        end
        else if (mapped_b)
        begin
            e.index_second = block_number(p.position_second, c.offset_bits);
            e.offset_valid = 1'b1;
            e.block_offset = in_block_offset(p.position_second, c);
        end
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Driver: when the channel is free, offers the next pending pair or, at random, idles.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pair_ch.valid             <= 1'b0;
            pair_ch.position_first    <= '0;
            pair_ch.position_second   <= '0;
            pair_ch.mismatches_first  <= '0;
            pair_ch.mismatches_second <= '0;
        end
        else if (!pair_ch.valid || pair_ch.ready)
        begin
            if (pairs_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                pair_item_t nxt;
                nxt = pairs_to_send.pop_front();
                pair_ch.position_first    <= nxt.position_first;
                pair_ch.position_second   <= nxt.position_second;
                pair_ch.mismatches_first  <= nxt.mismatches_first;
                pair_ch.mismatches_second <= nxt.mismatches_second;
                pair_ch.valid             <= 1'b1;
            end
            else
            begin
                pair_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, forced low during a requested hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Long hold-off, timed here so the stimulus process keeps running.
    always
    begin
        @(recv_hold_req);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted pairs, check accepted results in order.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, seen, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_ch.valid && pair_ch.ready)
                predicted_codes = {predicted_codes,
                                   encode_pair({pair_ch.position_first,
                                                pair_ch.position_second,
                                                pair_ch.mismatches_first,
                                                pair_ch.mismatches_second}, cfg_now)};
            if (result_ch.valid && result_ch.ready)
            begin
                encoding_t want;
                if (predicted_codes.size() == 0)
                begin
                    report_mismatch("unexpected result item", 64'd0, 64'd0);
                end
                else
                begin
                    want = predicted_codes.pop_front();
                    if (result_ch.block_index_first !== want.index_first)
                        report_mismatch("block_index_first", 64'(result_ch.block_index_first),
                                        64'(want.index_first));
                    if (result_ch.block_index_second !== want.index_second)
                        report_mismatch("block_index_second", 64'(result_ch.block_index_second),
                                        64'(want.index_second));
                    if (result_ch.offset_valid !== want.offset_valid)
                        report_mismatch("offset_valid", 64'(result_ch.offset_valid),
                                        64'(want.offset_valid));
                    if (result_ch.block_offset !== want.block_offset)
                        report_mismatch("block_offset", 64'(result_ch.block_offset),
                                        64'(want.block_offset));
                    if (result_ch.relation_valid !== want.relation_valid)
                        report_mismatch("relation_valid", 64'(result_ch.relation_valid),
                                        64'(want.relation_valid));
                    if (result_ch.pair_relation !== want.relation)
                        report_mismatch("pair_relation", 64'(result_ch.pair_relation),
                                        64'(want.relation));
                    if (result_ch.distance_value !== want.distance_value)
                        report_mismatch("distance_value", 64'(result_ch.distance_value),
                                        64'(want.distance_value));
                    if (result_ch.distance_bits !== want.distance_bits)
                        report_mismatch("distance_bits", 64'(result_ch.distance_bits),
                                        64'(want.distance_bits));
                end
            end
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
                $display("paired_alignment_position_encoder_tb: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [POS_W-1:0] rand_pos();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[POS_W-1:0];
    endfunction

    // Register write; the local copy follows the write right away since
    // writes only happen with nothing in flight.
    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_OFFSET_BIT_COUNT: cfg_now.offset_bits = val[COUNT_W-1:0];
            CFG_OFFSET_MASK:      cfg_now.offset_mask = val;
            CFG_INSERT_LIMIT:     cfg_now.insert_limit = val;
            CFG_INSERT_BIT_COUNT: cfg_now.insert_bits = val[COUNT_W-1:0];
            CFG_REFERENCE_LENGTH: cfg_now.reference_length = val;
            default: ;   // outside the map, block drops it
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pair(input logic [POS_W-1:0] p0, input logic [POS_W-1:0] p1,
                              input logic [MISMATCH_W-1:0] m0,
                              input logic [MISMATCH_W-1:0] m1);
        pairs_to_send = {pairs_to_send, pair_item_t'({p0, p1, m0, m1})};
    endtask

    // Blocks until every pending pair went in and every result came out.
    task automatic wait_drained();
        while (pairs_to_send.size() != 0 || pair_ch.valid || predicted_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [MISMATCH_W-1:0] rand_mismatches();
        case ($urandom_range(9, 0))
            0, 1:    return UNMAPPED;
            2:       return UNMAPPED - 32'd1;
            3, 4:    return 32'($urandom_range(20, 0));
            default: return $urandom;
        endcase
    endfunction

    // Mostly pairs whose distance sits near the interesting thresholds, the
    // rest unrelated or pinned to the ends of the position range.
    function automatic pair_item_t random_pair(input encoder_cfg_t c);
        pair_item_t       p;
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] delta;
        case ($urandom_range(3, 0))
            0:       base = c.reference_length - POS_W'($urandom_range(3000, 0));
            1:       base = POS_W'($urandom_range(100000, 0));
            default: base = rand_pos();
        endcase
        case ($urandom_range(4, 0))
            0:       delta = POS_W'($urandom_range(2000, 0));
            1:       delta = c.insert_limit - POS_W'($urandom_range(2, 0)) + 1;
            2:       delta = rand_pos();
            3:       delta = '0;
            default: delta = POS_W'($urandom_range(600, 0));
        endcase
        p.position_first = base;
        p.position_second = $urandom_range(1, 0) ? base + delta : base - delta;
        if ($urandom_range(9, 0) == 0)
        begin
            p.position_first = $urandom_range(1, 0) ? POS_MAX : '0;
            p.position_second = $urandom_range(1, 0) ? POS_MAX : rand_pos();
        end
        p.mismatches_first = rand_mismatches();
        p.mismatches_second = rand_mismatches();
        return p;
    endfunction

    // New random register setting, extremes included among the choices.
    task automatic random_setup();
        logic [COUNT_W-1:0] obits;
        obits = COUNT_W'($urandom_range(40, 1));
        if ($urandom_range(3, 0) == 0)
            obits = $urandom_range(1, 0) ? 6'd1 : 6'd40;
        set_reg(CFG_OFFSET_BIT_COUNT, {34'd0, obits});
        case ($urandom_range(3, 0))
            0:       set_reg(CFG_OFFSET_MASK, '1);
            1:       set_reg(CFG_OFFSET_MASK, '0);
            2:       set_reg(CFG_OFFSET_MASK, CFG_W'(ones_below(32'(obits))));
            default: set_reg(CFG_OFFSET_MASK, rand_pos());
        endcase
        case ($urandom_range(4, 0))
            0:       set_reg(CFG_INSERT_LIMIT, CFG_W'($urandom_range(4096, 0)));
            1:       set_reg(CFG_INSERT_LIMIT, rand_pos());
            2:       set_reg(CFG_INSERT_LIMIT, '0);
            3:       set_reg(CFG_INSERT_LIMIT, '1);
            default: set_reg(CFG_INSERT_LIMIT, CFG_W'($urandom_range(1 << 20, 0)));
        endcase
        set_reg(CFG_INSERT_BIT_COUNT, CFG_W'($urandom_range(40, 1)));
        case ($urandom_range(3, 0))
            0:       set_reg(CFG_REFERENCE_LENGTH, '0);
            1:       set_reg(CFG_REFERENCE_LENGTH, '1);
            2:       set_reg(CFG_REFERENCE_LENGTH, CFG_W'($urandom_range(200000, 0)));
            default: set_reg(CFG_REFERENCE_LENGTH, rand_pos());
        endcase
        end_writes();
    endtask

    task automatic run_batch(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int unsigned i = 0; i < count; i++)
            pairs_to_send = {pairs_to_send, random_pair(cfg_now)};
        // Receiver stops dead while the sender keeps pushing: the block has
        // to fill and drop pair ready.
        if (with_hold)
            -> recv_hold_req;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OFFSET_BIT_COUNT;
        cfg_data = '0;
        cfg_now = {OFFSET_BIT_COUNT_RST, OFFSET_MASK_RST, INSERT_LIMIT_RST,
                   INSERT_BIT_COUNT_RST, REFERENCE_LENGTH_RST};
        send_idle_pct = 25;
        recv_idle_pct = 53;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: 24 offset bits, limit 512, 9 near bits, no reference.
        queue_pair(POS_MAX, POS_MAX, UNMAPPED, UNMAPPED);            // neither mapped
        queue_pair(POS_MAX, '0, '0, UNMAPPED);                       // first only
        queue_pair('0, 40'h12_3456_789a, UNMAPPED, UNMAPPED - 32'd1); // second only
        queue_pair('0, '0, 32'd5, 32'd7);                            // same spot
        queue_pair(40'd1000, 40'd1300, 32'd0, 32'd1);                // near, after
        queue_pair(40'd1300, 40'd1000, 32'd2, 32'd0);                // near, before
        queue_pair('0, 40'd511, 32'd0, 32'd0);                       // just inside limit
        queue_pair('0, 40'd512, 32'd0, 32'd0);                       // far after, past ref end
        queue_pair(POS_MAX, 40'd5, 32'd3, 32'd3);                    // far before
        queue_pair(40'h55_5555_5555, 40'haa_aaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        queue_pair(40'haa_aaaa_aaaa, 40'h55_5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        wait_drained();

        // Widest shift, open mask, zero limit so every pair is far.
        set_reg(CFG_SPARE_FIRST, '0);
        set_reg(CFG_SPARE_LAST, '1);
        set_reg(CFG_OFFSET_BIT_COUNT, 40'd40);
        set_reg(CFG_OFFSET_MASK, '1);
        set_reg(CFG_INSERT_LIMIT, '0);
        set_reg(CFG_INSERT_BIT_COUNT, 40'd40);
        set_reg(CFG_REFERENCE_LENGTH, '1);
        end_writes();
        queue_pair('0, '0, 32'd0, 32'd0);                            // zero bit length
        queue_pair('0, POS_MAX, 32'd1, 32'd1);                       // room spans all bits
        queue_pair(POS_MAX, POS_MAX, 32'd9, UNMAPPED);
        queue_pair(40'd123, 40'd124, 32'd0, 32'd4);
        queue_pair(POS_MAX, '0, 32'd0, 32'd0);
        wait_drained();

        // Narrowest shift and near width, limit at the top.
        set_reg(CFG_OFFSET_BIT_COUNT, 40'd1);
        set_reg(CFG_OFFSET_MASK, 40'h55_5555_5555);
        set_reg(CFG_INSERT_LIMIT, '1);
        set_reg(CFG_INSERT_BIT_COUNT, 40'd1);
        set_reg(CFG_REFERENCE_LENGTH, 40'd1000);
        end_writes();
        queue_pair(40'd10, 40'd13, 32'd0, 32'd0);                    // distance truncated
        queue_pair(POS_MAX, '0, 32'd0, 32'd0);                       // distance == limit
        queue_pair('0, POS_MAX, 32'd0, 32'd0);                       // far after, small room
        queue_pair(40'd2000, 40'd2001, 32'd6, 32'd6);
        queue_pair(POS_MAX, POS_MAX, UNMAPPED, UNMAPPED);
        queue_pair(POS_MAX - 40'd1, 40'd3, 32'd7, UNMAPPED);
        wait_drained();

        // Random part: three idle profiles, two register settings each.
        random_setup();
        run_batch(BATCH_ITEMS, 25, 53, 1'b1);
        random_setup();
        run_batch(BATCH_ITEMS, 25, 53, 1'b0);
        random_setup();
        run_batch(BATCH_ITEMS, 53, 25, 1'b0);
        random_setup();
        run_batch(BATCH_ITEMS, 53, 25, 1'b1);
        random_setup();
        run_batch(BATCH_ITEMS, 0, 0, 1'b0);
        random_setup();
        run_batch(BATCH_ITEMS, 0, 0, 1'b0);

        if (error_count == 0)
            $display("paired_alignment_position_encoder_tb: clean");
        else
            $display("paired_alignment_position_encoder_tb: errors");
        $finish;
    end

endmodule
